@@ rtl/core/iee_pkg.sv @@
// Shared types and constants for the infix expression evaluator.
// Depends on nothing; imported by iee_unit and infix_expression_evaluator.
`default_nettype none
package iee_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_ADJ  = 2'd2;
  localparam logic [1:0] ERR_OVF  = 2'd3;

  localparam logic U_MUL = 1'b0;
  localparam logic U_DIV = 1'b1;

  localparam int FD_W = 24;

  typedef struct packed {
    logic start;
    logic op;
  } unit_req_t;

  function automatic logic [1:0] flag_err(input logic [1:0] cur, input logic [1:0] code);
    logic [1:0] r;
    r = cur;
    if (code == ERR_OVF) begin
      if (cur == ERR_OK) r = ERR_OVF;
    end else if (cur == ERR_OK || cur == ERR_OVF) begin
      r = code;
    end
    return r;
  endfunction

  function automatic logic [FD_W-1:0] pow10(input logic [2:0] idx);
    logic [FD_W-1:0] r;
    case (idx)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/iee_unit.sv @@
// Iterative multiply / restoring divide unit, one bit per cycle, one shared adder.
// Depends on iee_pkg.
`default_nettype none
module iee_unit #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  iee_pkg::unit_req_t                req,
  input  wire  [VALUE_WIDTH-1:0]            opa,
  input  wire  [VALUE_WIDTH+FRAC_BITS-1:0]  opn,
  output logic                              done,
  output logic [2*VALUE_WIDTH-1:0]          prod,
  output logic [VALUE_WIDTH+FRAC_BITS-1:0]  quo
);
  import iee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int L  = VALUE_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(L + 1);

  logic [W:0]    hi_r, hi_nxt;
  logic [L-1:0]  lo_r, lo_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          op_r, op_nxt;
  logic [W:0]    base, addend;
  logic [W+1:0]  s;
  logic [CW-1:0] last_cnt;

  always_comb begin
    base     = (op_r == U_MUL) ? hi_r : {hi_r[W-1:0], lo_r[L-1]};
    addend   = (op_r == U_MUL) ? {1'b0, a_r} : ~{1'b0, a_r};
    s        = {1'b0, base} + {1'b0, addend} + {{(W+1){1'b0}}, (op_r == U_DIV)};
    last_cnt = (op_r == U_MUL) ? CW'(W) : CW'(L);
    done     = busy_r && (cnt_r == last_cnt);
  end

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = opn;
      a_nxt    = opa;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      op_nxt   = req.op;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end else if (op_r == U_MUL) begin
        if (lo_r[0]) begin
          hi_nxt = {1'b0, s[W:1]};
          lo_nxt = {{(L-W){1'b0}}, s[0], lo_r[W-1:1]};
        end else begin
          hi_nxt = {1'b0, hi_r[W:1]};
          lo_nxt = {{(L-W){1'b0}}, hi_r[0], lo_r[W-1:1]};
        end
      end else begin
        if (s[W+1]) begin
          hi_nxt = s[W:0];
        end else begin
          hi_nxt = base;
        end
        lo_nxt = {lo_r[L-2:0], s[W+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= U_MUL;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    a_r  <= a_nxt;
  end

  assign prod = {hi_r[W-1:0], lo_r[W-1:0]};
  assign quo  = lo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("unit started while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r) else $error("unit still busy after done");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= CW'(L)) else $error("unit count out of range");

endmodule
`default_nettype wire

@@ rtl/core/infix_expression_evaluator.sv @@
// Top level: character stream in, expression result out; sequencer plus state.
// Depends on iee_pkg and iee_unit.
//
// Usage: in_tdata[7:0] carries one ASCII character per transaction, in_tlast marks
// the final character of an expression. Digits and '.' only update the number being
// parsed. An operator or the last character closes the current number: one fraction
// scaling through the shared divide unit, then the pending operator (add, subtract and
// divide by zero in the sequencer, multiply and divide through the shared unit), with
// the sequencing steps accept, unit start and final step around them.
// An operator marked last closes twice. in_tready is high only while idle.
// One result transaction follows each last character: out_tdata holds the signed
// fixed-point value and the status. A result waits in the output register; if the
// receiver stalls while the next result is ready, the block holds in its final
// step. Reset clears the parse and accumulation state (not num_r or neg_r, which are
// loaded before use) and drops any held result.
`default_nettype none
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH     = 48,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  input  wire  [7:0]                              in_tdata,  // symbol[7:0]
  input  wire                                     in_tlast,  // last
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  // value[VALUE_WIDTH-1:0], status[VALUE_WIDTH+1:VALUE_WIDTH], zero pad
  output logic [((VALUE_WIDTH+2+7)/8)*8-1:0]      out_tdata
);
  import iee_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int L   = VALUE_WIDTH + FRAC_BITS;
  localparam int IW  = VALUE_WIDTH - 1 - FRAC_BITS;
  localparam int M   = 2 * VALUE_WIDTH + 1;
  localparam int OW  = ((VALUE_WIDTH + 2 + 7) / 8) * 8;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_NUMW = 3'd2;
  localparam logic [2:0] S_OP   = 3'd3;
  localparam logic [2:0] S_OPW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] t;
    logic [W:0] r;
    t = {a[W-1], a} + {b[W-1], b};
    if (t[W] != t[W-1]) r = {1'b1, (t[W] ? MINV : MAXV)};
    else r = {1'b0, t[W-1:0]};
    return r;
  endfunction

  logic [2:0]      st_r, st_nxt;
  logic [W-1:0]    sum_r, sum_nxt, term_r, term_nxt, num_r, num_nxt;
  logic [1:0]      pend_r, pend_nxt, newop_r, newop_nxt, err_r, err_nxt;
  logic [IW-1:0]   int_r, int_nxt;
  logic [FD_W-1:0] fd_r, fd_nxt;
  logic [2:0]      fc_r, fc_nxt;
  logic            pt_r, pt_nxt, prior_r, prior_nxt, isop_r, isop_nxt;
  logic            last_r, last_nxt, neg_r, neg_nxt;
  logic            ov_r, ov_nxt;
  logic [W-1:0]    val_r, val_nxt;
  logic [1:0]      stat_r, stat_nxt;

  unit_req_t       u_req;
  logic [W-1:0]    u_a;
  logic [L-1:0]    u_n;
  logic            u_done;
  logic [2*W-1:0]  u_prod;
  logic [L-1:0]    u_quo;

  logic            acc;
  logic            sym_op;
  logic [1:0]      sym_code;
  logic [3:0]      dig;
  logic [IW+3:0]   int10;
  logic [L:0]      numw;
  logic [W-1:0]    tmag;
  logic [M-1:0]    pw, magw, limw;
  logic [W:0]      sa;
  logic [1:0]      err_fin;
  logic [FD_W-1:0] p10;

  iee_unit #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (u_req),
    .opa  (u_a),
    .opn  (u_n),
    .done (u_done),
    .prod (u_prod),
    .quo  (u_quo)
  );

  assign in_tready = (st_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    sym_op   = 1'b1;
    sym_code = OP_ADD;
    case (in_tdata)
      CH_PLUS:  sym_code = OP_ADD;
      CH_MINUS: sym_code = OP_SUB;
      CH_TIMES: sym_code = OP_MUL;
      CH_DIV:   sym_code = OP_DIV;
      default:  sym_op   = 1'b0;
    endcase
  end

  always_comb begin
    dig     = 4'(in_tdata - CH_ZERO);
    int10   = ({4'b0, int_r} << 3) + ({4'b0, int_r} << 1) + (IW+4)'(dig);
    p10     = pow10(fc_r);
    tmag    = term_r[W-1] ? (~term_r + W'(1)) : term_r;
    numw    = (L+1)'({int_r, {FRAC_BITS{1'b0}}}) + (L+1)'(u_quo);
    pw      = M'(u_prod) + (M'(1) << (FRAC_BITS - 1));
    magw    = (pend_r == OP_MUL) ? (pw >> FRAC_BITS) : M'(u_quo);
    limw    = M'(MAXV) + M'(neg_r);
    sa      = sat_add(sum_r, term_r);
    err_fin = sa[W] ? flag_err(err_r, ERR_OVF) : err_r;
  end

  always_comb begin
    st_nxt    = st_r;
    sum_nxt   = sum_r;
    term_nxt  = term_r;
    num_nxt   = num_r;
    pend_nxt  = pend_r;
    newop_nxt = newop_r;
    err_nxt   = err_r;
    int_nxt   = int_r;
    fd_nxt    = fd_r;
    fc_nxt    = fc_r;
    pt_nxt    = pt_r;
    prior_nxt = prior_r;
    isop_nxt  = isop_r;
    last_nxt  = last_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;
    u_req     = '{start: 1'b0, op: U_DIV};
    u_a       = W'(p10);
    u_n       = (L'(fd_r) << FRAC_BITS) + L'(p10 >> 1);

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (acc) begin
          last_nxt = in_tlast;
          isop_nxt = sym_op;
          if (sym_op) begin
            if (prior_r) err_nxt = flag_err(err_r, ERR_ADJ);
            newop_nxt = sym_code;
            prior_nxt = 1'b1;
          end else begin
            prior_nxt = 1'b0;
            if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
              if (pt_r) begin
                if (fc_r < 3'(MAX_FRAC_DIGITS)) begin
                  fd_nxt = (fd_r << 3) + (fd_r << 1) + FD_W'(dig);
                  fc_nxt = fc_r + 3'd1;
                end
              end else if (int10 > (IW+4)'({IW{1'b1}})) begin
                int_nxt = {IW{1'b1}};
                err_nxt = flag_err(err_r, ERR_OVF);
              end else begin
                int_nxt = int10[IW-1:0];
              end
            end else if (in_tdata == CH_POINT) begin
              pt_nxt = 1'b1;
            end
          end
          if (sym_op || in_tlast) st_nxt = S_NUM;
        end
      end
      S_NUM: begin
        u_req  = '{start: 1'b1, op: U_DIV};
        st_nxt = S_NUMW;
      end
      S_NUMW: begin
        if (u_done) begin
          if (numw > (L+1)'(MAXV)) begin
            num_nxt = MAXV;
            err_nxt = flag_err(err_r, ERR_OVF);
          end else begin
            num_nxt = numw[W-1:0];
          end
          st_nxt = S_OP;
        end
      end
      S_OP: begin
        neg_nxt = term_r[W-1];
        case (pend_r)
          OP_ADD, OP_SUB: begin
            sum_nxt  = sa[W-1:0];
            if (sa[W]) err_nxt = flag_err(err_r, ERR_OVF);
            term_nxt = (pend_r == OP_SUB) ? (~num_r + W'(1)) : num_r;
            st_nxt   = S_FIN;
          end
          OP_MUL: begin
            u_req  = '{start: 1'b1, op: U_MUL};
            u_a    = tmag;
            u_n    = L'(num_r);
            st_nxt = S_OPW;
          end
          default: begin
            if (num_r == '0) begin
              err_nxt = flag_err(err_r, ERR_DIV0);
              st_nxt  = S_FIN;
            end else begin
              u_req  = '{start: 1'b1, op: U_DIV};
              u_a    = num_r;
              u_n    = (L'(tmag) << FRAC_BITS) + L'(num_r >> 1);
              st_nxt = S_OPW;
            end
          end
        endcase
      end
      S_OPW: begin
        if (u_done) begin
          if (magw > limw) begin
            err_nxt  = flag_err(err_r, ERR_OVF);
            term_nxt = neg_r ? (~limw[W-1:0] + W'(1)) : limw[W-1:0];
          end else begin
            term_nxt = neg_r ? (~magw[W-1:0] + W'(1)) : magw[W-1:0];
          end
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        int_nxt = '0;
        fd_nxt  = '0;
        fc_nxt  = '0;
        pt_nxt  = 1'b0;
        if (isop_r) begin
          pend_nxt = newop_r;
          isop_nxt = 1'b0;
          st_nxt   = last_r ? S_NUM : S_IDLE;
        end else if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          val_nxt   = (err_fin == ERR_DIV0 || err_fin == ERR_ADJ) ? '0 : sa[W-1:0];
          stat_nxt  = err_fin;
          sum_nxt   = '0;
          term_nxt  = '0;
          pend_nxt  = OP_ADD;
          prior_nxt = 1'b0;
          err_nxt   = ERR_OK;
          last_nxt  = 1'b0;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      sum_r   <= '0;
      term_r  <= '0;
      pend_r  <= OP_ADD;
      newop_r <= OP_ADD;
      err_r   <= ERR_OK;
      int_r   <= '0;
      fd_r    <= '0;
      fc_r    <= '0;
      pt_r    <= 1'b0;
      prior_r <= 1'b0;
      isop_r  <= 1'b0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      sum_r   <= sum_nxt;
      term_r  <= term_nxt;
      pend_r  <= pend_nxt;
      newop_r <= newop_nxt;
      err_r   <= err_nxt;
      int_r   <= int_nxt;
      fd_r    <= fd_nxt;
      fc_r    <= fc_nxt;
      pt_r    <= pt_nxt;
      prior_r <= prior_nxt;
      isop_r  <= isop_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    val_r  <= val_nxt;
    stat_r <= stat_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OW'({stat_r, val_r});

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (st_r == S_NUMW || st_r == S_OPW)) else $error("unit done outside wait");
  a_load_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_FIN) else $error("result loaded outside final step");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (stat_r == ERR_DIV0 || stat_r == ERR_ADJ) |-> val_r == '0)
    else $error("error result not zero");
  a_fc_max: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= 3'(MAX_FRAC_DIGITS)) else $error("fraction count too large");

endmodule
`default_nettype wire
